@@ hw/rtl/asf_pkg.sv @@
// Shared types, constants and the exponential curve table for the segment fade block.
// No dependencies; every other file of the block imports it.
package asf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int LENGTH_BITS = 16;
  localparam int CURVE_DEPTH = 256;
  localparam int CURVE_IDX_BITS = $clog2(CURVE_DEPTH);

  // Gain is unsigned Q1.24
  localparam int GAIN_FRAC = 24;
  localparam int GAIN_BITS = GAIN_FRAC + 1;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC;

  // Envelope product and scaled sample widths
  localparam int PROD_BITS = 2 * GAIN_BITS;
  localparam int SCALE_BITS = SAMPLE_BITS + GAIN_BITS + 1;

  // Stream payload widths, padded to whole bytes
  localparam int IN_FIELD_BITS = SAMPLE_BITS + LENGTH_BITS;
  localparam int IN_DATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_USER_BITS = 3;
  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  // tuser bit positions
  localparam int USER_FIRST = 0;
  localparam int USER_FADE_IN = 1;
  localparam int USER_FADE_OUT = 2;

  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_IN   = 2'd1,
    MODE_OUT  = 2'd2,
    MODE_BOTH = 2'd3
  } fade_mode_t;

  typedef logic [GAIN_BITS-1:0] curve_t [0:CURVE_DEPTH];

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic mix;
    logic scale;
    logic finish;
  } asf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_busy;
    logic out_busy;
  } asf_stat_t;

  // Entry k holds 2^(k/DEPTH) - 1 in Q1.24, from a Taylor series in Q30
  function automatic curve_t build_curve();
    curve_t t;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int k = 0; k < CURVE_DEPTH; k++) begin
      x = (64'(k) * LN2_Q30) / CURVE_DEPTH;
      term = 64'd1 << 30;
      sum = term;
      for (int n = 1; n <= 16; n++) begin
        term = ((term * x) >> 30) / 64'(n);
        sum = sum + term;
      end
      v = (sum - (64'd1 << 30) + 64'd32) >> 6;
      if (v > 64'(GAIN_ONE)) v = 64'(GAIN_ONE);
      t[k] = GAIN_BITS'(v);
    end
    t[CURVE_DEPTH] = GAIN_ONE;
    return t;
  endfunction

  localparam curve_t CURVE = build_curve();

endpackage

@@ hw/rtl/asf_recip.sv @@
// Bit-serial restoring divider that forms the per-sample gain decrement 2^24 / length.
// Uses asf_pkg; one quotient bit per cycle.
module asf_recip
  import asf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [LENGTH_BITS-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [GAIN_BITS-1:0]   quotient
);

  localparam int CNT_BITS = $clog2(GAIN_BITS);

  logic [CNT_BITS-1:0]    count;
  logic [LENGTH_BITS-1:0] dvsr;
  logic [LENGTH_BITS-1:0] rem;
  logic [GAIN_BITS-1:0]   numer;
  logic [GAIN_BITS-1:0]   quo;
  logic [LENGTH_BITS:0]   trial;
  logic                   fit;

  // Bring down the next dividend bit and test against the divisor
  assign trial = {rem, numer[GAIN_BITS-1]};
  assign fit = trial >= {1'b0, dvsr};

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CNT_BITS'(GAIN_BITS - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift remainder, dividend and quotient one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      rem <= '0;
      numer <= GAIN_ONE;
      quo <= '0;
    end else if (busy) begin
      rem <= fit ? LENGTH_BITS'(trial - {1'b0, dvsr}) : trial[LENGTH_BITS-1:0];
      numer <= {numer[GAIN_BITS-2:0], 1'b0};
      quo <= {quo[GAIN_BITS-2:0], fit};
    end
  end

  assign quotient = quo;

endmodule

@@ hw/rtl/asf_datapath.sv @@
// Datapath of the segment fade: segment state, envelope multiplier, sample scaling and
// the output register. Uses asf_pkg and asf_recip; steered by asf_ctrl commands.
module asf_datapath
  import asf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  asf_cmd_t                 cmd,
  output asf_stat_t                stat,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  input  logic [IN_USER_BITS-1:0]  s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  localparam int SHIFT_BITS = SCALE_BITS - GAIN_FRAC;
  localparam int FRAC_LOW = GAIN_FRAC - CURVE_IDX_BITS;
  localparam logic [PROD_BITS-1:0] RND_CURVE = PROD_BITS'(1) << (GAIN_FRAC - 1);
  localparam logic [PROD_BITS-1:0] RND_BOTH = PROD_BITS'(1) << (GAIN_FRAC - 2);
  localparam logic signed [SCALE_BITS-1:0] RND_SCALE = SCALE_BITS'(1) << (GAIN_FRAC - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Request fields
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [LENGTH_BITS-1:0]        in_length;
  logic                          in_first;

  // Segment state
  fade_mode_t             fade_mode;
  logic [LENGTH_BITS-1:0] sample_index;
  logic [LENGTH_BITS-1:0] span_length;
  logic [GAIN_BITS-1:0]   gain_step;
  logic [GAIN_BITS-1:0]   gain_level;

  // Working registers
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [PROD_BITS-1:0]          prod;
  logic [GAIN_BITS-1:0]          curve_base;
  logic [GAIN_BITS-1:0]          env;
  logic signed [SCALE_BITS-1:0]  acc;

  // Divider
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [GAIN_BITS-1:0] div_quot;

  // Envelope operands
  logic [CURVE_IDX_BITS:0]  tab_idx;
  logic [GAIN_FRAC-1:0]     tab_frac;
  logic [GAIN_BITS-1:0]     tab_lo;
  logic [GAIN_BITS-1:0]     tab_hi;
  logic [GAIN_BITS-1:0]     tab_diff;
  logic [GAIN_BITS-1:0]     mul_a;
  logic [GAIN_BITS-1:0]     mul_b;
  logic [SHIFT_BITS-1:0]    scaled;
  logic [SAMPLE_BITS-1:0]   sat_sample;
  logic                     active;
  logic                     pass;

  assign in_sample = $signed(s_tdata[SAMPLE_BITS-1:0]);
  assign in_length = s_tdata[SAMPLE_BITS +: LENGTH_BITS];
  assign in_first = s_tuser[USER_FIRST];

  assign div_start = cmd.load && in_first && (in_length != '0);

  asf_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (in_length),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign active = sample_index < span_length;
  assign pass = (fade_mode == MODE_PASS) || !active;

  // Segment state: latch on a first sample, advance after each sample inside the span
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_mode <= MODE_PASS;
      sample_index <= '0;
      span_length <= '0;
      gain_step <= '0;
      gain_level <= GAIN_ONE;
    end else begin
      if (cmd.load && in_first) begin
        fade_mode <= fade_mode_t'({s_tuser[USER_FADE_OUT], s_tuser[USER_FADE_IN]});
        span_length <= in_length;
        sample_index <= '0;
        gain_level <= GAIN_ONE;
        gain_step <= '0;
      end
      if (div_done) begin
        gain_step <= div_quot;
      end
      if (cmd.finish && active) begin
        gain_level <= (gain_level > gain_step) ? gain_level - gain_step : '0;
        sample_index <= sample_index + 1'b1;
      end
    end
  end

  // Curve lookup: integer part picks the segment, fraction interpolates
  assign tab_idx = gain_level[GAIN_BITS-1 -: CURVE_IDX_BITS+1];
  assign tab_frac = {gain_level[FRAC_LOW-1:0], {CURVE_IDX_BITS{1'b0}}};
  assign tab_lo = CURVE[tab_idx];
  assign tab_hi = tab_idx[CURVE_IDX_BITS] ? CURVE[CURVE_DEPTH]
                                          : CURVE[tab_idx + 1'b1];
  assign tab_diff = (tab_hi >= tab_lo) ? tab_hi - tab_lo : '0;

  // Share one multiplier between interpolation and the parabolic envelope
  assign mul_a = (fade_mode == MODE_OUT) ? tab_diff : gain_level;
  assign mul_b = (fade_mode == MODE_OUT) ? {1'b0, tab_frac} : GAIN_ONE - gain_level;

  // Envelope and scaling stages
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= in_sample;
    end
    if (cmd.mul) begin
      prod <= mul_a * mul_b;
      curve_base <= tab_lo;
    end
    if (cmd.mix) begin
      case (fade_mode)
        MODE_IN:   env <= GAIN_ONE - gain_level;
        MODE_OUT:  env <= curve_base + GAIN_BITS'((prod + RND_CURVE) >> GAIN_FRAC);
        MODE_BOTH: env <= GAIN_BITS'((prod + RND_BOTH) >> (GAIN_FRAC - 1));
        default:   env <= GAIN_ONE;
      endcase
    end
    if (cmd.scale) begin
      acc <= smp * $signed({1'b0, env}) + RND_SCALE;
    end
  end

  // Drop the fraction and saturate to the sample range
  assign scaled = acc[SCALE_BITS-1:GAIN_FRAC];
  always_comb begin
    if (scaled[SHIFT_BITS-1:SAMPLE_BITS-1] == '0
        || scaled[SHIFT_BITS-1:SAMPLE_BITS-1] == '1) begin
      sat_sample = scaled[SAMPLE_BITS-1:0];
    end else if (scaled[SHIFT_BITS-1]) begin
      sat_sample = SMP_MIN;
    end else begin
      sat_sample = SMP_MAX;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= OUT_DATA_BITS'(pass ? smp : sat_sample);
    end
  end

  // Hold the controller until the quotient has landed in gain_step
  assign stat.div_busy = div_busy || div_done;
  assign stat.out_busy = m_tvalid && !m_tready;

`ifndef NO_ASSERTIONS
  // Position never runs past the latched span
  assert property (@(posedge clk) disable iff (rst) sample_index <= span_length)
    else $error("sample index beyond span length");

  // Gain stays within [0, 1.0]
  assert property (@(posedge clk) disable iff (rst) gain_level <= GAIN_ONE)
    else $error("gain level above unity");
`endif

endmodule

@@ hw/rtl/asf_ctrl.sv @@
// Controller of the segment fade: sequences load, envelope, scaling and output steps.
// Uses asf_pkg; drives asf_datapath through asf_cmd_t and reads asf_stat_t.
module asf_ctrl
  import asf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output asf_cmd_t  cmd,
  input  asf_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_SCALE,
    ST_FIN
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands from the current state
  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold until the step size is known and the output register is free
        cmd.finish = !stat.div_busy && !stat.out_busy;
        if (cmd.finish) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

`ifndef NO_ASSERTIONS
  // A sample completes only after the reciprocal is settled
  assert property (@(posedge clk) disable iff (rst) cmd.finish |-> !stat.div_busy)
    else $error("finish while divider busy");

  // An accepted request starts the envelope step next cycle
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == ST_MUL)
    else $error("load not followed by multiply step");
`endif

endmodule

@@ hw/rtl/audio_segment_fade.sv @@
// Segment fade envelope: one result per request, each sample through load, envelope
// multiply, combine, scale and write. A first sample with nonzero length also runs the
// bit-serial reciprocal, and its write waits until the step is stored in gain_step.
// A new request is taken while the previous result still waits in the output register.
// Reset (rst, synchronous) returns to pass-through with gain 1.0 and an empty output.
module audio_segment_fade
  import asf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,  // sample_in, segment_length
  input  logic [IN_USER_BITS-1:0]  s_tuser,  // first, fade_in_flag, fade_out_flag
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata   // sample_out
);

  asf_cmd_t  cmd;
  asf_stat_t stat;

  asf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  asf_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ verif/audio_segment_fade_chk.sv @@
// Scoreboard for audio_segment_fade: predicts each faded sample from the accepted requests
// and compares it with the result stream. Depends on asf_pkg for widths and field positions.
`timescale 1ns / 1ps

module audio_segment_fade_chk
  import asf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,  // sample_in, segment_length
  input  logic [IN_USER_BITS-1:0]  s_tuser,  // first, fade_in_flag, fade_out_flag
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [OUT_DATA_BITS-1:0] m_tdata,  // sample_out
  output int                       fail_count,
  output int                       pending,
  output int                       checked
);

  localparam longint unsigned UNITY = 64'd1 << GAIN_FRAC;
  localparam longint unsigned LN2_FRAC30 = 64'd744261118;
  localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  // Envelope state of the segment in progress
  fade_mode_t             env_mode;
  logic [LENGTH_BITS-1:0] pos;
  logic [LENGTH_BITS-1:0] span;
  logic [GAIN_BITS-1:0]   step;
  logic [GAIN_BITS-1:0]   level;

  longint unsigned exp_curve [0:CURVE_DEPTH];
  logic [SAMPLE_BITS-1:0] faded_q [$];

  // Build the 2^g - 1 table from a 16-term series in Q30
  initial begin : curve_init
    longint unsigned x, term, total, v;
    for (int k = 0; k < CURVE_DEPTH; k++) begin
      x = (longint'(k) * LN2_FRAC30) / CURVE_DEPTH;
      term = 64'd1 << 30;
      total = term;
      for (int n = 1; n <= 16; n++) begin
        term = ((term * x) >> 30) / n;
        total += term;
      end
      v = (total - (64'd1 << 30) + 64'd32) >> 6;
      if (v > UNITY) v = UNITY;
      exp_curve[k] = v;
    end
    exp_curve[CURVE_DEPTH] = UNITY;
  end

  // Advance the envelope by one request and return the faded sample
  function automatic logic [SAMPLE_BITS-1:0] faded_sample(
    input logic [SAMPLE_BITS-1:0]  smp,
    input logic [IN_USER_BITS-1:0] flags,
    input logic [LENGTH_BITS-1:0]  len
  );
    longint s, m, q;
    longint unsigned g, p, f, a, b;
    logic [SAMPLE_BITS-1:0] r;
    s = longint'($signed(smp));
    r = smp;
    if (flags[USER_FIRST]) begin
      env_mode = fade_mode_t'({flags[USER_FADE_OUT], flags[USER_FADE_IN]});
      span = len;
      pos = '0;
      level = GAIN_ONE;
      step = (len != 0) ? GAIN_BITS'(UNITY / longint'(len)) : '0;
    end
    if (pos < span) begin
      g = longint'(level);
      case (env_mode)
        MODE_IN: begin
          m = UNITY - g;
        end
        MODE_OUT: begin
          // Interpolate between neighboring table entries
          p = g * CURVE_DEPTH;
          f = p & (UNITY - 1);
          if ((p >> GAIN_FRAC) >= CURVE_DEPTH) begin
            m = exp_curve[CURVE_DEPTH];
          end else begin
            a = exp_curve[p >> GAIN_FRAC];
            b = exp_curve[(p >> GAIN_FRAC) + 1];
            if (b < a) b = a;
            m = a + (((b - a) * f + (64'd1 << 23)) >> 24);
          end
        end
        MODE_BOTH: begin
          m = (g * (UNITY - g) + (64'd1 << 22)) >> 23;
        end
        default: begin
          // Unity gain reproduces the sample exactly
          m = UNITY;
        end
      endcase
      q = (s * m + (longint'(1) << 23)) >>> 24;
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      r = q[SAMPLE_BITS-1:0];
      level = (level > step) ? level - step : '0;
      pos = pos + 1'b1;
    end
    return r;
  endfunction

  // Retire results before queuing new requests so that order holds within one edge
  always @(posedge clk) begin
    logic [SAMPLE_BITS-1:0] want;
    if (rst) begin
      env_mode = MODE_PASS;
      pos = '0;
      span = '0;
      step = '0;
      level = GAIN_ONE;
      faded_q.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (faded_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("%t: result %h with no request pending", $realtime, m_tdata);
        end else begin
          want = faded_q.pop_front();
          checked <= checked + 1;
          if (m_tdata[SAMPLE_BITS-1:0] !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("%t: sample_out expected %h (%0d) got %h (%0d)", $realtime, want,
                       $signed(want), m_tdata[SAMPLE_BITS-1:0],
                       $signed(m_tdata[SAMPLE_BITS-1:0]));
          end
        end
      end
      if (s_tvalid && s_tready)
        faded_q.insert(faded_q.size(),
                       faded_sample(s_tdata[SAMPLE_BITS-1:0], s_tuser,
                                    s_tdata[SAMPLE_BITS +: LENGTH_BITS]));
    end
    pending <= faded_q.size();
  end

endmodule

@@ verif/audio_segment_fade_tb.sv @@
// Top of the audio_segment_fade bench: clock, reset, request stimulus and result backpressure.
// Depends on asf_pkg, the block itself and the audio_segment_fade_chk scoreboard.
`timescale 1ns / 1ps

module audio_segment_fade_tb;
  import asf_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;   // sample_in, segment_length
  logic [IN_USER_BITS-1:0]  s_tuser = '0;   // first, fade_in_flag, fade_out_flag
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;        // sample_out

  int fail_count;
  int pending;
  int checked;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cnt = 0;
  int requests = 0;
  int segments = 0;
  int mode_hits [4] = '{0, 0, 0, 0};

  audio_segment_fade u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  audio_segment_fade_chk u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      hold_cnt <= $urandom_range(0, 17);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Mostly random samples, with the rails and zero mixed in
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      1: return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      2: return '0;
      3: return SAMPLE_BITS'($signed($urandom_range(0, 64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Drive one request, after an optional gap, and hold it until accepted
  task automatic send_request(
    input logic [SAMPLE_BITS-1:0] smp,
    input logic                   first,
    input logic                   fade_in,
    input logic                   fade_out,
    input logic [LENGTH_BITS-1:0] len
  );
    logic [IN_USER_BITS-1:0] u;
    u = '0;
    u[USER_FIRST] = first;
    u[USER_FADE_IN] = fade_in;
    u[USER_FADE_OUT] = fade_out;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {len, smp};
    s_tuser <= u;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests++;
    if (first) begin
      segments++;
      mode_hits[{fade_out, fade_in}]++;
    end
  endtask

  // Open a segment and follow it with n-1 plain samples carrying ignored junk
  task automatic play_segment(
    input logic                   fade_in,
    input logic                   fade_out,
    input logic [LENGTH_BITS-1:0] len,
    input int                     n
  );
    send_request(pick_sample(), 1'b1, fade_in, fade_out, len);
    for (int k = 1; k < n; k++)
      send_request(pick_sample(), 1'b0, 1'($urandom), 1'($urandom), LENGTH_BITS'($urandom));
  endtask

  initial begin
    logic [LENGTH_BITS-1:0] len;
    int n;
    bit pressed;
    pressed = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: pass-through before any segment, then every mode at the rails
    gap_pct = 15;
    stall_pct = 10;
    send_request(24'h7fffff, 1'b0, 1'b0, 1'b0, 16'h0000);
    send_request(24'h800000, 1'b0, 1'b1, 1'b1, 16'hffff);
    send_request(24'h7fffff, 1'b1, 1'b1, 1'b0, 16'd3);
    send_request(24'h800000, 1'b0, 1'b0, 1'b0, 16'd0);
    send_request(24'h7fffff, 1'b0, 1'b0, 1'b0, 16'd0);
    send_request(24'h7fffff, 1'b1, 1'b0, 1'b1, 16'd3);
    send_request(24'h800000, 1'b0, 1'b0, 1'b0, 16'd0);
    send_request(24'h400000, 1'b0, 1'b0, 1'b0, 16'd0);
    send_request(24'h800000, 1'b1, 1'b1, 1'b1, 16'd3);
    send_request(24'h7fffff, 1'b0, 1'b0, 1'b0, 16'd0);
    send_request(24'h800000, 1'b0, 1'b0, 1'b0, 16'd0);
    send_request(24'h7fffff, 1'b1, 1'b0, 1'b0, 16'd2);
    send_request(24'h800000, 1'b0, 1'b1, 1'b1, 16'd7);
    // Zero length: every sample passes, the first one too
    send_request(24'h7fffff, 1'b1, 1'b1, 1'b1, 16'd0);
    send_request(24'h800000, 1'b0, 1'b0, 1'b0, 16'd0);
    send_request(24'h123456, 1'b0, 1'b0, 1'b0, 16'd0);
    // Past the end of a one-sample segment
    send_request(24'h7fffff, 1'b1, 1'b1, 1'b0, 16'd1);
    send_request(24'h800000, 1'b0, 1'b0, 1'b0, 16'd0);
    send_request(24'h7fffff, 1'b0, 1'b1, 1'b0, 16'd0);
    // Longest segment, gain barely moves
    send_request(24'h800000, 1'b1, 1'b0, 1'b1, 16'hffff);
    send_request(24'h7fffff, 1'b0, 1'b0, 1'b0, 16'd0);
    send_request(24'h000001, 1'b1, 1'b1, 1'b1, 16'h8000);

    // Hold off until the block has drained
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);

    // Random segments; idling profile changes every 64 requests, none near the end
    while (requests < 530) begin
      if (requests >= 480) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        case ((requests / 64) % 4)
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 10; stall_pct = 5;  end
          2: begin gap_pct = 40; stall_pct = 20; end
          default: begin gap_pct = 5; stall_pct = 40; end
        endcase
      end
      if (!pressed && requests >= 300) begin
        pressed = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
      end
      case ($urandom_range(0, 9))
        0: len = '0;
        1, 2: len = LENGTH_BITS'($urandom_range(0, 65535));
        default: len = LENGTH_BITS'($urandom_range(1, 20));
      endcase
      n = (len <= 20) ? int'(len) + $urandom_range(0, 3) : $urandom_range(1, 24);
      // Cut some segments short before the envelope ends
      if (len > 1 && len <= 20 && $urandom_range(0, 7) == 0)
        n = $urandom_range(1, int'(len) - 1);
      if (n == 0) n = 1;
      play_segment(1'($urandom), 1'($urandom), len, n);
    end

    // Drain and let the pipeline settle
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);

    $display("Ran %0d requests in %0d segments (pass %0d, in %0d, out %0d, both %0d).",
             requests, segments, mode_hits[MODE_PASS], mode_hits[MODE_IN],
             mode_hits[MODE_OUT], mode_hits[MODE_BOTH]);
    $display("Checked %0d results, %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a stuck handshake
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/asf_pkg.sv
hw/rtl/asf_recip.sv
hw/rtl/asf_datapath.sv
hw/rtl/asf_ctrl.sv
hw/rtl/audio_segment_fade.sv
verif/audio_segment_fade_chk.sv
verif/audio_segment_fade_tb.sv
